// ===== design/scit_pkg.sv =====
// Shared constants, types and the quarter-wave sine table for the
// sine/cosine interpolated-table pipeline. No dependencies.
package scit_pkg;

  localparam int TablePoints    = 11;
  localparam int AngleFracBits  = 16;
  localparam int ResultFracBits = 14;
  localparam int AngleW         = 32;
  localparam int ResultW        = 16;

  // pi = 3.141592654 in Q30; multiples of pi/2 rounded half up to the angle format
  localparam longint PiQ30       = 64'sd3373259426;
  localparam int     ConstShift  = 31 - AngleFracBits;
  localparam longint ConstRnd    = longint'(1) << (ConstShift - 1);
  localparam longint HalfPi      = (PiQ30 * 1 + ConstRnd) >>> ConstShift;
  localparam longint Pi          = (PiQ30 * 2 + ConstRnd) >>> ConstShift;
  localparam longint ThreeHalfPi = (PiQ30 * 3 + ConstRnd) >>> ConstShift;
  localparam longint TwoPi       = (PiQ30 * 4 + ConstRnd) >>> ConstShift;

  // Angle reduction: bias by a multiple of 2*pi so the dividend is never negative
  localparam int     UW         = AngleW + 1;
  localparam longint OffsetMult = ((longint'(1) << (AngleW - 1)) + HalfPi) / TwoPi + 1;
  localparam longint Offset     = OffsetMult * TwoPi;
  localparam int     TPW        = $clog2(TwoPi + 1);
  localparam int     QW         = $clog2((longint'(1) << UW) / TwoPi + 2);
  localparam int     RW         = $clog2(2 * TwoPi);
  localparam int     Drop       = $clog2(TwoPi) - 2;
  localparam int     UHW        = UW - Drop;
  localparam int     RecipShift = UHW + 2;
  localparam longint Recip      = (longint'(1) << (RecipShift + Drop)) / TwoPi;
  localparam int     RecipW     = $clog2(Recip + 1);

  // Interpolation
  localparam int     FW          = $clog2(HalfPi + 1);
  localparam int     IW          = $clog2(TablePoints);
  localparam int     TW          = FW + $clog2(TablePoints);
  localparam int     YW          = ResultFracBits + 1;
  localparam int     PW          = YW + FW;
  localparam longint RoundHalf   = HalfPi / 2;
  localparam int     Drop2       = $clog2(HalfPi) - 2;
  localparam int     PHW         = PW - Drop2;
  localparam int     Recip2Shift = PHW + 2;
  localparam longint Recip2      = (longint'(1) << (Recip2Shift + Drop2)) / HalfPi;
  localparam int     Recip2W     = $clog2(Recip2 + 1);
  localparam int     RRW         = $clog2(2 * HalfPi);

  localparam int ReduceStages = 5;
  localparam int InterpStages = 5;
  localparam int NumStages    = ReduceStages + InterpStages;

  // sin(i * pi/20), Q14, rounded half up
  localparam logic [YW-1:0] SineTable [TablePoints] = '{
    0, 2563, 5063, 7438, 9630, 11585, 13255, 14598, 15582, 16182, 16384
  };

  typedef struct packed {
    logic          neg;
    logic [FW-1:0] mag;
  } fold_t;

endpackage

// ===== design/scit_if.sv =====
// Valid/ready channel interfaces for the sine/cosine pipeline.
// Depends on scit_pkg for field widths.
interface scit_in_if;
  logic                                valid;
  logic                                ready;
  logic                                kind;
  logic signed [scit_pkg::AngleW-1:0]  angle;

  modport source (output valid, kind, angle, input ready);
  modport sink   (input valid, kind, angle, output ready);
endinterface

interface scit_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [scit_pkg::ResultW-1:0] wave_value;

  modport source (output valid, wave_value, input ready);
  modport sink   (input valid, wave_value, output ready);
endinterface

// ===== design/scit_reduce.sv =====
// Angle reduction modulo 2*pi and quadrant fold into [0, pi/2].
// Five register stages, each loaded by its own enable. Depends on scit_pkg.
module scit_reduce (
  input  logic                                    clk_i,
  input  logic [scit_pkg::ReduceStages-1:0]       en_i,
  input  logic                                    kind_i,
  input  logic signed [scit_pkg::AngleW-1:0]      angle_i,
  output scit_pkg::fold_t                         fold_o
);

  localparam int UW  = scit_pkg::UW;
  localparam int RW  = scit_pkg::RW;
  localparam int TPW = scit_pkg::TPW;
  localparam int FW  = scit_pkg::FW;
  localparam int QW  = scit_pkg::QW;
  localparam int UHW = scit_pkg::UHW;
  localparam int RecipW = scit_pkg::RecipW;

  localparam logic signed [UW:0] SinBase = (UW+1)'(scit_pkg::Offset);
  localparam logic signed [UW:0] CosBase = (UW+1)'(scit_pkg::Offset + scit_pkg::HalfPi);
  localparam logic [RecipW-1:0]  RecipC  = RecipW'(scit_pkg::Recip);
  localparam logic [TPW-1:0]     TwoPiC  = TPW'(scit_pkg::TwoPi);
  localparam logic [TPW-1:0]     PiC     = TPW'(scit_pkg::Pi);
  localparam logic [TPW-1:0]     HalfC   = TPW'(scit_pkg::HalfPi);
  localparam logic [TPW-1:0]     ThreeC  = TPW'(scit_pkg::ThreeHalfPi);

  // Stage 1: cosine as sine of pi/2 - angle, biased non-negative
  logic signed [UW:0] a_ext;
  logic signed [UW:0] u_d;
  logic [UW-1:0]      u_q;

  always_comb begin
    a_ext = {{(UW + 1 - scit_pkg::AngleW){angle_i[scit_pkg::AngleW-1]}}, angle_i};
    u_d   = kind_i ? (CosBase - a_ext) : (SinBase + a_ext);
  end

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      u_q <= u_d[UW-1:0];
    end
  end

  // Stage 2: quotient estimate by reciprocal, low by at most one
  logic [UHW+RecipW-1:0] qprod;
  logic [QW-1:0]         q_q;
  logic [RW-1:0]         ulo_q;

  assign qprod = u_q[UW-1:scit_pkg::Drop] * RecipC;

  always_ff @(posedge clk_i) begin
    if (en_i[1]) begin
      q_q   <= qprod[scit_pkg::RecipShift +: QW];
      ulo_q <= u_q[RW-1:0];
    end
  end

  // Stage 3: coarse remainder, below 2*(2*pi), so low bits suffice
  logic [QW+TPW-1:0] mprod;
  logic [RW-1:0]     r0_q;

  assign mprod = q_q * TwoPiC;

  always_ff @(posedge clk_i) begin
    if (en_i[2]) begin
      r0_q <= ulo_q - mprod[RW-1:0];
    end
  end

  // Stage 4: final correction
  logic [TPW-1:0] r_q;

  always_ff @(posedge clk_i) begin
    if (en_i[3]) begin
      r_q <= (r0_q >= RW'(scit_pkg::TwoPi)) ? TPW'(r0_q - RW'(scit_pkg::TwoPi))
                                            : TPW'(r0_q);
    end
  end

  // Stage 5: quadrant fold
  scit_pkg::fold_t fold_d;
  scit_pkg::fold_t fold_q;

  always_comb begin
    priority if (r_q < HalfC) begin
      fold_d.mag = FW'(r_q);
      fold_d.neg = 1'b0;
    end else if (r_q < PiC) begin
      fold_d.mag = FW'(PiC - r_q);
      fold_d.neg = 1'b0;
    end else if (r_q < ThreeC) begin
      fold_d.mag = FW'(r_q - PiC);
      fold_d.neg = 1'b1;
    end else begin
      fold_d.mag = FW'(TwoPiC - r_q);
      fold_d.neg = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[4]) begin
      fold_q <= fold_d;
    end
  end

  assign fold_o = fold_q;

endmodule

// ===== design/scit_interp.sv =====
// Table lookup and linear interpolation of a folded angle, then sign.
// Five register stages, each loaded by its own enable. Depends on scit_pkg.
module scit_interp (
  input  logic                                    clk_i,
  input  logic [scit_pkg::InterpStages-1:0]       en_i,
  input  scit_pkg::fold_t                         fold_i,
  output logic signed [scit_pkg::ResultW-1:0]     wave_value_o
);

  localparam int TW  = scit_pkg::TW;
  localparam int FW  = scit_pkg::FW;
  localparam int IW  = scit_pkg::IW;
  localparam int YW  = scit_pkg::YW;
  localparam int PW  = scit_pkg::PW;
  localparam int PHW = scit_pkg::PHW;
  localparam int RRW = scit_pkg::RRW;
  localparam int Recip2W = scit_pkg::Recip2W;
  localparam int ResultW = scit_pkg::ResultW;
  localparam int TablePoints = scit_pkg::TablePoints;

  localparam logic [Recip2W-1:0] Recip2C = Recip2W'(scit_pkg::Recip2);
  localparam logic [FW-1:0]      HalfC   = FW'(scit_pkg::HalfPi);

  // Stage 6: segment index and offset within it (t = f * segments)
  logic [TW-1:0] t;
  logic [TW-1:0] base;
  logic [IW-1:0] idx_d, idx_q;
  logic [FW-1:0] rem_d, rem_q;
  logic          neg6_q;

  always_comb begin
    t     = TW'(fold_i.mag) * TW'(TablePoints - 1);
    idx_d = '0;
    base  = '0;
    for (int k = 1; k < TablePoints - 1; k++) begin
      if (t >= TW'(k * scit_pkg::HalfPi)) begin
        idx_d = IW'(k);
        base  = TW'(k * scit_pkg::HalfPi);
      end
    end
    // exactly pi/2: last segment at full weight
    if (t >= TW'((TablePoints - 1) * scit_pkg::HalfPi)) begin
      idx_d = IW'(TablePoints - 2);
      rem_d = HalfC;
    end else begin
      rem_d = FW'(t - base);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      idx_q  <= idx_d;
      rem_q  <= rem_d;
      neg6_q <= fold_i.neg;
    end
  end

  // Stage 7: slope times offset, plus half a step for rounding
  logic [IW-1:0] idx_nx;
  logic [YW-1:0] y0, y1, dy;
  logic [PW-1:0] p2_d, p2_q;
  logic [YW-1:0] y0_7_q;
  logic          neg7_q;

  always_comb begin
    idx_nx = idx_q + IW'(1);
    y0     = scit_pkg::SineTable[idx_q];
    y1     = scit_pkg::SineTable[idx_nx];
    dy     = y1 - y0;
    p2_d   = dy * rem_q + PW'(scit_pkg::RoundHalf);
  end

  always_ff @(posedge clk_i) begin
    if (en_i[1]) begin
      p2_q   <= p2_d;
      y0_7_q <= y0;
      neg7_q <= neg6_q;
    end
  end

  // Stage 8: quotient estimate of p2 / (pi/2), low by at most one
  logic [PHW+Recip2W-1:0] qprod;
  logic [YW-1:0]          qe_q;
  logic [RRW-1:0]         p2lo_q;
  logic [YW-1:0]          y0_8_q;
  logic                   neg8_q;

  assign qprod = p2_q[PW-1:scit_pkg::Drop2] * Recip2C;

  always_ff @(posedge clk_i) begin
    if (en_i[2]) begin
      qe_q   <= qprod[scit_pkg::Recip2Shift +: YW];
      p2lo_q <= p2_q[RRW-1:0];
      y0_8_q <= y0_7_q;
      neg8_q <= neg7_q;
    end
  end

  // Stage 9: remainder of the estimate
  logic [YW+FW-1:0] mprod;
  logic [RRW-1:0]   rr_q;
  logic [YW-1:0]    qe9_q;
  logic [YW-1:0]    y0_9_q;
  logic             neg9_q;

  assign mprod = qe_q * HalfC;

  always_ff @(posedge clk_i) begin
    if (en_i[3]) begin
      rr_q   <= p2lo_q - mprod[RRW-1:0];
      qe9_q  <= qe_q;
      y0_9_q <= y0_8_q;
      neg9_q <= neg8_q;
    end
  end

  // Stage 10: correct quotient, add base point, apply sign
  logic [YW-1:0]             frac;
  logic [YW-1:0]             mag;
  logic signed [ResultW-1:0] mag_s;
  logic signed [ResultW-1:0] wave_d, wave_q;

  always_comb begin
    frac   = qe9_q + YW'(rr_q >= RRW'(scit_pkg::HalfPi));
    mag    = y0_9_q + frac;
    mag_s  = ResultW'(mag);
    wave_d = neg9_q ? -mag_s : mag_s;
  end

  always_ff @(posedge clk_i) begin
    if (en_i[4]) begin
      wave_q <= wave_d;
    end
  end

  assign wave_value_o = wave_q;

endmodule

// ===== design/sine_cosine_interpolated_table.sv =====
// Top level of the sine/cosine pipeline: stage valid bits and flow control,
// reduction and interpolation datapaths. Depends on scit_pkg, scit_if, scit_reduce, scit_interp.
//
//  channel | dir | handshake   | payload
//  req_i   | in  | valid/ready | kind (0 sine, 1 cosine), angle (Q.16 radians)
//  rsp_o   | out | valid/ready | wave_value (Q.14, one result per request)
//
// Ten register stages; one request accepted per cycle unless all stages are full and the output stalls.
// Two reciprocal multiplies (mod 2*pi and the interpolation divide) set the depth.
// Reset clears the stage valid bits only; datapath registers are not reset.
// Each stage loads when it is empty or the stage after it moves, so bubbles
// close up under a stalled output and ready falls only when all stages hold data.
module sine_cosine_interpolated_table (
  input  logic       clk_i,
  input  logic       rst_ni,
  scit_in_if.sink    req_i,
  scit_out_if.source rsp_o
);

  localparam int NumStages    = scit_pkg::NumStages;
  localparam int ReduceStages = scit_pkg::ReduceStages;

  logic [NumStages-1:0] v_q, v_d, en;
  scit_pkg::fold_t      fold;

  always_comb begin
    en[NumStages-1] = ~v_q[NumStages-1] | rsp_o.ready;
    for (int k = NumStages - 2; k >= 0; k--) begin
      en[k] = ~v_q[k] | en[k+1];
    end
    v_d[0] = en[0] ? req_i.valid : v_q[0];
    for (int k = 1; k < NumStages; k++) begin
      v_d[k] = en[k] ? v_q[k-1] : v_q[k];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= v_d;
    end
  end

  assign req_i.ready = en[0];
  assign rsp_o.valid = v_q[NumStages-1];

  scit_reduce u_reduce (
    .clk_i   (clk_i),
    .en_i    (en[ReduceStages-1:0]),
    .kind_i  (req_i.kind),
    .angle_i (req_i.angle),
    .fold_o  (fold)
  );

  scit_interp u_interp (
    .clk_i        (clk_i),
    .en_i         (en[NumStages-1:ReduceStages]),
    .fold_i       (fold),
    .wave_value_o (rsp_o.wave_value)
  );

`ifndef SYNTH
  // result never exceeds one in magnitude
  a_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid |->
      ($signed(rsp_o.wave_value) <= $signed(scit_pkg::ResultW'(1 << scit_pkg::ResultFracBits))
       && $signed(rsp_o.wave_value) >=
          -$signed(scit_pkg::ResultW'(1 << scit_pkg::ResultFracBits))))
    else $error("wave_value out of range");

  // back-pressure only when every stage holds a request
  a_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !req_i.ready |-> (&v_q))
    else $error("ready low with a free stage");

  // requests in flight change by accepted minus delivered
  a_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(rst_ni) |->
      (int'($countones(v_q)) == int'($past($countones(v_q)))
        + int'($past(req_i.valid && req_i.ready))
        - int'($past(rsp_o.valid && rsp_o.ready))))
    else $error("request lost or duplicated in pipeline");
`endif

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps
// Testbench for sine_cosine_interpolated_table: random and directed angle requests,
// results checked against a fixed-point table-interpolation predictor in a scoreboard.
// Depends on scit_pkg, scit_if and the RTL of the block.
module tb;

  localparam logic KindSine = 1'b0;
  localparam logic KindCos  = 1'b1;

  // pi = 3.141592654 in Q30, multiples of pi/2 rounded half up to Q16
  localparam longint PiQ30        = 64'sd3373259426;
  localparam longint HalfPiQ30    = 64'sd1686629713;
  localparam longint OneQ30       = 64'sd1073741824;
  localparam longint QuarterTurn  = (PiQ30 * 1 + 16384) >>> 15;
  localparam longint HalfTurn     = (PiQ30 * 2 + 16384) >>> 15;
  localparam longint ThreeQuarter = (PiQ30 * 3 + 16384) >>> 15;
  localparam longint FullTurn     = (PiQ30 * 4 + 16384) >>> 15;
  localparam int     Segments     = 10;

  localparam int NumRequests = 1900;
  localparam int CalmTail    = 200;
  localparam int HoldCycles  = 64;
  localparam int StallLimit  = 1000;
  localparam int SettleWait  = 20;

  class wave_scoreboard;
    logic signed [scit_pkg::ResultW-1:0] expected_waves[$];
    longint quarter_table[Segments + 1];
    int     fails;

    function new();
      longint x;
      fails = 0;
      for (int i = 0; i <= Segments; i++) begin
        x = (HalfPiQ30 * i + Segments / 2) / Segments;
        quarter_table[i] = (taylor_sine_q30(x) + (64'sd1 <<< 15)) >>> 16;
      end
    endfunction

    function longint taylor_sine_q30(longint x);
      longint x2, term, sum;
      x2   = (x * x) >>> 30;
      term = x;
      sum  = x;
      for (int k = 1; k <= 8; k++) begin
        term = (term * x2) / OneQ30;
        term = -term / longint'((2 * k) * (2 * k + 1));
        sum += term;
      end
      if (sum < 0) sum = 0;
      if (sum > OneQ30) sum = OneQ30;
      return sum;
    endfunction

    function logic signed [scit_pkg::ResultW-1:0] predict_wave(
        logic kind, logic signed [scit_pkg::AngleW-1:0] angle);
      longint a, r, f, t, idx, rem, y0, y1, y;
      bit     neg;
      a = longint'(angle);
      if (kind == KindCos) a = QuarterTurn - a;
      r = a % FullTurn;
      if (r < 0) r += FullTurn;
      if (r < QuarterTurn) begin
        f = r; neg = 0;
      end else if (r < HalfTurn) begin
        f = HalfTurn - r; neg = 0;
      end else if (r < ThreeQuarter) begin
        f = r - HalfTurn; neg = 1;
      end else begin
        f = FullTurn - r; neg = 1;
      end
      t   = f * Segments;
      idx = t / QuarterTurn;
      rem = t % QuarterTurn;
      // folded angle of exactly pi/2 takes the last segment at full weight
      if (idx >= Segments) begin
        idx = Segments - 1;
        rem = QuarterTurn;
      end
      y0 = quarter_table[idx];
      y1 = quarter_table[idx + 1];
      y  = (y0 * QuarterTurn + (y1 - y0) * rem + QuarterTurn / 2) / QuarterTurn;
      if (neg) y = -y;
      return y[scit_pkg::ResultW-1:0];
    endfunction

    function void note_request(logic kind, logic signed [scit_pkg::AngleW-1:0] angle);
      expected_waves.push_back(predict_wave(kind, angle));
    endfunction

    function void check_wave(logic signed [scit_pkg::ResultW-1:0] got);
      logic signed [scit_pkg::ResultW-1:0] want;
      if (expected_waves.size() == 0) begin
        fails++;
        if (fails <= 10) $display("ERROR: unexpected result %0d", got);
      end else begin
        want = expected_waves.pop_front();
        if (got !== want) begin
          fails++;
          if (fails <= 10) $display("ERROR: wave_value expected %0d got %0d", want, got);
        end
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni;

  scit_in_if  req_if ();
  scit_out_if rsp_if ();

  sine_cosine_interpolated_table dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  wave_scoreboard sb = new();

  int accepted_reqs = 0;
  bit calm          = 0;
  bit holding       = 0;
  bit tx_gappy      = 1;

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (req_if.valid && req_if.ready) begin
        sb.note_request(req_if.kind, req_if.angle);
        accepted_reqs++;
      end
      if (rsp_if.valid && rsp_if.ready) sb.check_wave(rsp_if.wave_value);
    end
  end

  task automatic send_request(logic kind, logic signed [scit_pkg::AngleW-1:0] angle);
    if ($urandom_range(0, 79) == 0) tx_gappy = !tx_gappy;
    if (!calm && !holding && tx_gappy && $urandom_range(0, 2) == 0) begin
      req_if.valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk_i);
    end
    req_if.valid <= 1'b1;
    req_if.kind  <= kind;
    req_if.angle <= angle;
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);
  endtask

  function automatic logic signed [scit_pkg::AngleW-1:0] random_angle();
    longint a;
    case ($urandom_range(0, 9))
      0, 1, 2: a = longint'($signed($urandom()));
      3, 4, 5, 6: a = longint'($urandom_range(0, 8 * FullTurn)) - 4 * FullTurn;
      // just around a multiple of pi/2
      7, 8: a = (longint'($urandom_range(0, 40)) - 20) * QuarterTurn
                + longint'($urandom_range(0, 6)) - 3;
      // around an interior table knot
      default: a = (longint'($urandom_range(0, 15)) - 8) * QuarterTurn
                   + (QuarterTurn * $urandom_range(1, Segments - 1)) / Segments
                   + longint'($urandom_range(0, 4)) - 2;
    endcase
    return a[scit_pkg::AngleW-1:0];
  endfunction

  // output side: random stalls, one long hold-off to back the pipeline up
  initial begin
    bit stall_mode;
    bit hold_done;
    stall_mode = 1;
    hold_done  = 0;
    rsp_if.ready = 1'b0;
    @(posedge clk_i);
    while (!rst_ni) @(posedge clk_i);
    forever begin
      if ($urandom_range(0, 199) == 0) stall_mode = !stall_mode;
      if (!hold_done && accepted_reqs >= 400) begin
        rsp_if.ready <= 1'b0;
        holding <= 1'b1;
        repeat (HoldCycles) @(posedge clk_i);
        holding <= 1'b0;
        hold_done = 1;
      end else if (!calm && stall_mode && $urandom_range(0, 3) == 0) begin
        rsp_if.ready <= 1'b0;
        repeat ($urandom_range(1, 14)) @(posedge clk_i);
      end else begin
        rsp_if.ready <= 1'b1;
        @(posedge clk_i);
      end
    end
  end

  // watchdog: cycles with no request or result accepted
  initial begin
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < StallLimit) begin
      @(posedge clk_i);
      if (!rst_ni || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("sine_cosine_interpolated_table test failed");
    $finish;
  end

  initial begin
    int directed;
    rst_ni       = 1'b0;
    req_if.valid = 1'b0;
    req_if.kind  = KindSine;
    req_if.angle = '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_request(KindSine, 32'sd0);
    send_request(KindSine, 32'sd1);
    send_request(KindSine, -32'sd1);
    send_request(KindSine, 32'(QuarterTurn));       // folds to exactly pi/2
    send_request(KindSine, 32'(QuarterTurn - 1));
    send_request(KindSine, 32'(HalfTurn - 1));
    send_request(KindSine, 32'(HalfTurn));
    send_request(KindSine, 32'(ThreeQuarter - 1));
    send_request(KindSine, 32'(ThreeQuarter));
    send_request(KindSine, 32'(FullTurn - 1));
    send_request(KindSine, 32'(FullTurn));
    send_request(KindSine, 32'(-QuarterTurn));
    send_request(KindSine, 32'(QuarterTurn / 2));   // exact table knot
    send_request(KindSine, 32'h8000_0000);
    send_request(KindSine, 32'h7fff_ffff);
    send_request(KindCos, 32'sd0);
    send_request(KindCos, 32'h8000_0000);           // pi/2 - angle must not wrap
    send_request(KindCos, 32'h7fff_ffff);
    send_request(KindCos, 32'(QuarterTurn));
    send_request(KindCos, 32'(-QuarterTurn));
    send_request(KindCos, 32'(HalfTurn));
    send_request(KindCos, 32'(-FullTurn));
    send_request(KindCos, -32'sd1);
    directed = 23;

    for (int n = directed; n < NumRequests; n++) begin
      if (n >= NumRequests - CalmTail) calm = 1;
      send_request(logic'($urandom_range(0, 1)), random_angle());
    end
    req_if.valid <= 1'b0;

    while (sb.expected_waves.size() != 0) @(posedge clk_i);
    repeat (SettleWait) @(posedge clk_i);

    if (sb.fails == 0) begin
      $display("sine_cosine_interpolated_table test passed");
    end else begin
      $display("sine_cosine_interpolated_table test failed");
    end
    $finish;
  end

endmodule
